>>> design/scph_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scph_pkg
// Shared constants, types and register codes of the spectrum column peak hold.
// ----------------------------------------------------------------------------
package scph_pkg;

	localparam int DISPLAY_COLUMNS = 128;
	localparam int DATA_W          = 16;
	localparam int COL_W           = $clog2(DISPLAY_COLUMNS);
	localparam int OUT_COL_W       = 7;
	localparam int HALF_COLUMNS    = DISPLAY_COLUMNS / 2;
	localparam int NUM_W           = DATA_W + COL_W;
	localparam int DEN_W           = DATA_W + 1;
	localparam int PROD_W          = 2 * DATA_W;
	localparam int GAIN_FRAC       = 8;
	localparam int FIFO_DEPTH      = 2;
	localparam int CFG_REGS        = 8;
	localparam int CFG_IDX_W       = $clog2(CFG_REGS);

	localparam logic [DATA_W-1:0] LOW_BAND_MIN = 16'd1080;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_FROM      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_TO        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_STEP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BAND_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_BAND_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_BAND_MAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BAND_GAIN  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_BAND_GAIN = 3'd7;

	typedef struct packed {
		logic [DATA_W-1:0] scan_from;
		logic [DATA_W-1:0] scan_to;
		logic [DATA_W-1:0] scan_step;
		logic [DATA_W-1:0] low_band_max;
		logic [DATA_W-1:0] high_band_min;
		logic [DATA_W-1:0] high_band_max;
		logic [DATA_W-1:0] low_band_gain;
		logic [DATA_W-1:0] high_band_gain;
	} cfg_t;

	// classified sample, handed from front to back through the queue
	typedef struct packed {
		logic              start;
		logic              skip;
		logic              high;
		logic [DATA_W-1:0] diff;
		logic [DATA_W-1:0] step;
		logic [NUM_W-1:0]  num;
		logic [PROD_W-1:0] prod;
	} entry_t;

	typedef struct packed {
		logic [OUT_COL_W-1:0] column;
		logic [DATA_W-1:0]    column_peak;
		logic                 in_range;
	} res_t;

endpackage
`default_nettype wire

>>> design/scph_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scph_in_if
// Sample channel: valid/ready handshake with one scanner sample as payload.
// ----------------------------------------------------------------------------
interface scph_in_if import scph_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] sample_freq;
	logic [DATA_W-1:0] signal_level;
	logic              scan_start;

	modport source (output valid, output sample_freq, output signal_level,
		output scan_start, input ready);
	modport sink (input valid, input sample_freq, input signal_level,
		input scan_start, output ready);
endinterface
`default_nettype wire

>>> design/scph_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scph_out_if
// Result channel: valid/ready handshake with one placed column as payload.
// ----------------------------------------------------------------------------
interface scph_out_if import scph_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OUT_COL_W-1:0] column;
	logic [DATA_W-1:0]    column_peak;
	logic                 in_range;

	modport source (output valid, output column, output column_peak,
		output in_range, input ready);
	modport sink (input valid, input column, input column_peak,
		input in_range, output ready);
endinterface
`default_nettype wire

>>> design/scph_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scph_front
// Classifies a sample: picks its band, clips the scan range, flags early skips
// and forms the column numerator and the gain product.
// ----------------------------------------------------------------------------
module scph_front import scph_pkg::*; (
	input  var cfg_t              cfg,
	input  wire [DATA_W-1:0]      sample_freq,
	input  wire [DATA_W-1:0]      signal_level,
	input  wire                   scan_start,
	output var entry_t            entry
);

	logic              high;
	logic              low;
	logic [DATA_W-1:0] from_h;
	logic [DATA_W-1:0] to_h;
	logic [DATA_W-1:0] from_l;
	logic [DATA_W-1:0] to_l;
	logic [DATA_W-1:0] from;
	logic [DATA_W-1:0] to;
	logic [DATA_W-1:0] gain;
	logic [DATA_W-1:0] fdiff;

	always_comb begin
		high   = sample_freq > cfg.high_band_min;
		low    = sample_freq < cfg.low_band_max;
		from_h = (cfg.scan_from >= cfg.high_band_min) ? cfg.scan_from : cfg.high_band_min;
		to_h   = (cfg.scan_to < cfg.high_band_max) ? cfg.scan_to : cfg.high_band_max;
		from_l = (cfg.scan_from < cfg.low_band_max) ? cfg.scan_from : LOW_BAND_MIN;
		to_l   = (cfg.scan_to < cfg.low_band_max) ? cfg.scan_to : cfg.low_band_max;
		from   = high ? from_h : from_l;
		to     = high ? to_h : to_l;
		gain   = high ? cfg.high_band_gain : cfg.low_band_gain;
		fdiff  = sample_freq - from;

		entry.start = scan_start;
		entry.high  = high;
		entry.skip  = !(high || low) || (cfg.scan_step == '0) || (to <= from)
			|| (sample_freq < from);
		entry.diff  = to - from;
		entry.step  = cfg.scan_step;
		entry.num   = NUM_W'(fdiff) * NUM_W'(DISPLAY_COLUMNS - 1);
		entry.prod  = PROD_W'(signal_level) * PROD_W'(gain);
	end

endmodule
`default_nettype wire

>>> design/scph_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scph_fifo
// Short queue of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module scph_fifo import scph_pkg::*; (
	input  wire    clk,
	input  wire    arst_n,
	input  wire    push,
	input  var entry_t push_data,
	input  wire    pop,
	output var entry_t head,
	output logic   full,
	output logic   not_empty
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	entry_t             slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full      = cnt_q == CNT_W'(FIFO_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

>>> design/scph_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scph_div
// Restoring divider, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module scph_div import scph_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire [NUM_W-1:0]  dividend,
	input  wire [DEN_W-1:0]  divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient,
	output logic [DEN_W-1:0] remainder
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   trial;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		trial   = shifted - {1'b0, dvs_q};
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], !trial[DEN_W]};
			rem_q <= trial[DEN_W] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> design/scph_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scph_back
// Executes queued samples: start-flag restart, the two column divisions,
// new-column clearing, peak hold in the column store, and the result register.
// ----------------------------------------------------------------------------
module scph_back import scph_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	input  var entry_t     head,
	input  wire            not_empty,
	output logic           pop,
	scph_out_if.source     results
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIV1 = 6'b000010,
		S_DIV2 = 6'b000100,
		S_MARK = 6'b001000,
		S_UPD  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	localparam logic [COL_W-1:0] HALF_COL = COL_W'(HALF_COLUMNS);

	state_t                 state_q;
	entry_t                 ent_q;
	res_t                   res_q;
	res_t                   out_q;
	logic                   out_valid_q;
	logic [COL_W-1:0]       col_q;
	logic [COL_W-1:0]       low_trk_q;
	logic [COL_W-1:0]       high_trk_q;
	logic [DISPLAY_COLUMNS-1:0] valid_q;
	logic [DATA_W-1:0]      mem [DISPLAY_COLUMNS];
	logic [DATA_W-1:0]      rdata_q;

	logic                   div_start;
	logic [NUM_W-1:0]       div_dividend;
	logic [DEN_W-1:0]       div_divisor;
	logic                   div_done;
	logic [NUM_W-1:0]       div_quo;
	logic [DEN_W-1:0]       div_rem;

	logic [NUM_W:0]         col_sum;
	logic [COL_W-1:0]       tracker;
	logic [COL_W-1:0]       limit;
	logic [COL_W-1:0]       col_next;
	logic [DATA_W-1:0]      old_peak;
	logic [DATA_W-1:0]      scaled;
	logic [DATA_W-1:0]      new_peak;
	logic                   mem_we;
	logic                   out_free;

	scph_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		pop          = (state_q == S_IDLE) && not_empty;
		div_start    = 1'b0;
		div_dividend = NUM_W'(head.diff);
		div_divisor  = DEN_W'(head.step);
		if (state_q == S_IDLE) begin
			div_start = not_empty && !head.skip;
		end else if (state_q == S_DIV1) begin
			div_start    = div_done && (div_quo != '0);
			div_dividend = ent_q.num;
			// count * step is diff less the remainder
			div_divisor  = {ent_q.diff - div_rem[DATA_W-1:0], 1'b0};
		end

		col_sum  = {1'b0, div_quo} + (ent_q.high ? (NUM_W + 1)'(HALF_COLUMNS) : '0);
		tracker  = ent_q.high ? high_trk_q : low_trk_q;
		limit    = ent_q.high ? COL_W'(DISPLAY_COLUMNS - 1) : COL_W'(HALF_COLUMNS - 1);
		col_next = col_q + COL_W'(1);

		old_peak = valid_q[col_q] ? rdata_q : '0;
		scaled   = (|ent_q.prod[PROD_W-1:DATA_W + GAIN_FRAC]) ? '1
			: ent_q.prod[DATA_W + GAIN_FRAC - 1:GAIN_FRAC];
		new_peak = (scaled > old_peak) ? scaled : old_peak;
		mem_we   = state_q == S_UPD;
		out_free = !out_valid_q || results.ready;
	end

	// column store: registered read at the current column
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[col_q] <= new_peak;
		rdata_q <= mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (pop)
			ent_q <= head;
		if (state_q == S_DIV2 && div_done)
			col_q <= col_sum[COL_W-1:0];
		if (state_q == S_OUT && out_free)
			out_q <= res_q;
		case (state_q)
			S_IDLE: res_q <= '0;
			S_UPD: begin
				res_q.column      <= OUT_COL_W'(col_q);
				res_q.column_peak <= new_peak;
				res_q.in_range    <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			low_trk_q   <= '0;
			high_trk_q  <= HALF_COL;
			valid_q     <= '0;
		end else begin
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (not_empty) begin
						if (head.start) begin
							low_trk_q         <= '0;
							high_trk_q        <= HALF_COL;
							valid_q[0]        <= 1'b0;
							valid_q[HALF_COL] <= 1'b0;
						end
						state_q <= head.skip ? S_OUT : S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done)
						state_q <= (div_quo == '0) ? S_OUT : S_DIV2;
				end
				S_DIV2: begin
					if (div_done)
						state_q <= (col_sum >= (NUM_W + 1)'(DISPLAY_COLUMNS)) ? S_OUT : S_MARK;
				end
				S_MARK: begin
					// new column: take it, clear it and, inside the band, its right neighbor
					if (col_q != tracker) begin
						if (ent_q.high)
							high_trk_q <= col_q;
						else
							low_trk_q <= col_q;
						valid_q[col_q] <= 1'b0;
						if (col_q < limit)
							valid_q[col_next] <= 1'b0;
					end
					state_q <= S_UPD;
				end
				S_UPD: begin
					valid_q[col_q] <= 1'b1;
					state_q        <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid       = out_valid_q;
	assign results.column      = out_q.column;
	assign results.column_peak = out_q.column_peak;
	assign results.in_range    = out_q.in_range;

endmodule
`default_nettype wire

>>> design/spectrum_column_peak_hold.sv
`default_nettype none
// Flow: a placed sample passes twice through the shared one-bit-per-cycle
//   divider before its result is raised; a skipped one bypasses the divider,
//   a zero count ends after the first pass and a column past the width after
//   the second. The back end takes one sample at a time; the queue holds two
//   samples ahead.
// Reset: asynchronous; column store reads as zero at once through valid bits.
// ----------------------------------------------------------------------------
// spectrum_column_peak_hold
// Two-band spectrum column store with per-column peak hold for a display.
// ----------------------------------------------------------------------------
module spectrum_column_peak_hold import scph_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [DATA_W-1:0]    cfg_wdata,
	scph_in_if.sink             samples,
	scph_out_if.source          results
);

	cfg_t   cfg_q;
	entry_t entry;
	entry_t head;
	logic   full;
	logic   not_empty;
	logic   pop;
	logic   push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_from      <= 16'd0;
			cfg_q.scan_to        <= 16'd65535;
			cfg_q.scan_step      <= 16'd1;
			cfg_q.low_band_max   <= 16'd1360;
			cfg_q.high_band_min  <= 16'd5300;
			cfg_q.high_band_max  <= 16'd6000;
			cfg_q.low_band_gain  <= 16'd256;
			cfg_q.high_band_gain <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCAN_FROM:      cfg_q.scan_from      <= cfg_wdata;
				REG_SCAN_TO:        cfg_q.scan_to        <= cfg_wdata;
				REG_SCAN_STEP:      cfg_q.scan_step      <= cfg_wdata;
				REG_LOW_BAND_MAX:   cfg_q.low_band_max   <= cfg_wdata;
				REG_HIGH_BAND_MIN:  cfg_q.high_band_min  <= cfg_wdata;
				REG_HIGH_BAND_MAX:  cfg_q.high_band_max  <= cfg_wdata;
				REG_LOW_BAND_GAIN:  cfg_q.low_band_gain  <= cfg_wdata;
				REG_HIGH_BAND_GAIN: cfg_q.high_band_gain <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign samples.ready = !full;
	assign push          = samples.valid && !full;

	scph_front u_front (
		.cfg          (cfg_q),
		.sample_freq  (samples.sample_freq),
		.signal_level (samples.signal_level),
		.scan_start   (samples.scan_start),
		.entry        (entry)
	);

	scph_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.not_empty (not_empty)
	);

	scph_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.results   (results)
	);

endmodule
`default_nettype wire
